// ===== hdl/cll_pkg.sv =====
package cll_pkg;

    localparam logic [3:0] CMD_PUSH_FRONT = 4'd0;
    localparam logic [3:0] CMD_PUSH_BACK  = 4'd1;
    localparam logic [3:0] CMD_POP_FRONT  = 4'd2;
    localparam logic [3:0] CMD_POP_BACK   = 4'd3;
    localparam logic [3:0] CMD_FIND       = 4'd4;
    localparam logic [3:0] CMD_ERASE      = 4'd5;
    localparam logic [3:0] CMD_INSERT     = 4'd6;
    localparam logic [3:0] CMD_REMOVE_ALL = 4'd7;
    localparam logic [3:0] CMD_CLEAR      = 4'd8;

    typedef logic [1:0] status_t;

    localparam status_t STAT_OK    = 2'd0;
    localparam status_t STAT_EMPTY = 2'd1;
    localparam status_t STAT_FULL  = 2'd2;
    localparam status_t STAT_RANGE = 2'd3;

endpackage

// ===== hdl/cursor_linked_list_engine_top.sv =====
// Linked list engine: a singly linked list of 32-bit values held in two
// node memories (data and next link) with a free chain of spare nodes.
// Command channel: drive cmd, value and position with start high; the beat
// is taken at a rising edge where start is high and busy is low. Exactly one
// result beat follows, shown for one cycle with done high: status, value_out,
// found, found_position, removed_count and list_length. The receiver cannot
// stall; a result is never held, and the next command may be taken in the
// cycle its predecessor's result is shown.
// Clear, unknown and rejected commands finish in S_IDLE; push, pop front,
// insert at either end and erase at the head pass through S_ADD or S_POPF.
// Pop back and erase at the tail take S_PB0, a walk to the node before the
// tail if the list holds more than one node, and S_PBF; erase and insert in
// the body walk to the node before the position, then take S_ER0 to S_ER2 or
// S_IN0 to S_IN2; find and remove all search in S_FIND and S_RM. The walks
// advance one node per cycle, set by the single read port of the link memory,
// whose registered output feeds the next read address; remove all adds S_RM2
// for each node it unlinks after a survivor. After reset the engine is busy
// while a clearing pass rebuilds the free chain; the list then starts empty.
module cursor_linked_list_engine_top #(
    parameter int NODE_COUNT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  cmd,
    input  logic [31:0] value,
    input  logic [6:0]  position,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] value_out,
    output logic        found,
    output logic [5:0]  found_position,
    output logic [6:0]  removed_count,
    output logic [6:0]  list_length
);

    localparam int IW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int CW = $clog2(NODE_COUNT + 1);
    localparam int PW = ((CW > 7) ? CW : 7) + 1;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_ADD  = 4'd2;
    localparam logic [3:0] S_POPF = 4'd3;
    localparam logic [3:0] S_PB0  = 4'd4;
    localparam logic [3:0] S_PBF  = 4'd5;
    localparam logic [3:0] S_WALK = 4'd6;
    localparam logic [3:0] S_ER0  = 4'd7;
    localparam logic [3:0] S_ER1  = 4'd8;
    localparam logic [3:0] S_ER2  = 4'd9;
    localparam logic [3:0] S_IN0  = 4'd10;
    localparam logic [3:0] S_IN1  = 4'd11;
    localparam logic [3:0] S_IN2  = 4'd12;
    localparam logic [3:0] S_FIND = 4'd13;
    localparam logic [3:0] S_RM   = 4'd14;
    localparam logic [3:0] S_RM2  = 4'd15;

    logic [CW-1:0] next_mem [NODE_COUNT];
    logic [31:0]   data_mem [NODE_COUNT];
    logic [CW-1:0] next_q;
    logic [31:0]   data_q;

    logic [IW-1:0] raddr;
    logic          nwe;
    logic [IW-1:0] nwa;
    logic [CW-1:0] nwd;
    logic          dwe;
    logic [IW-1:0] dwa;
    logic [31:0]   dwd;

    logic [3:0]    state_reg, state_next;
    logic [3:0]    ret_reg, ret_next;
    logic [IW-1:0] clr_reg, clr_next;
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [CW-1:0] spare_reg, spare_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [IW-1:0] prev_reg, prev_next;
    logic [IW-1:0] node_reg, node_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] raw_reg, raw_next;
    logic          hasprev_reg, hasprev_next;
    logic          back_reg, back_next;
    logic [31:0]   val_reg, val_next;
    logic [31:0]   vout_reg, vout_next;
    logic [CW-1:0] rm_reg, rm_next;

    logic          done_reg, done_next;
    logic [1:0]    st_res_reg, st_res_next;
    logic [31:0]   vout_res_reg, vout_res_next;
    logic          found_res_reg, found_res_next;
    logic [5:0]    fpos_res_reg, fpos_res_next;
    logic [6:0]    rm_res_reg, rm_res_next;
    logic [6:0]    len_res_reg, len_res_next;

    logic          full, empty;
    logic [PW-1:0] pos_w, cnt_w;

    function automatic logic [IW-1:0] nix(input logic [CW-1:0] v);
        nix = (v < CW'(NODE_COUNT)) ? v[IW-1:0] : '0;
    endfunction

    assign full  = (count_reg == CW'(NODE_COUNT));
    assign empty = (count_reg == '0);
    assign pos_w = PW'(position);
    assign cnt_w = PW'(count_reg);

    always_ff @(posedge clk)
    begin
        next_q <= next_mem[raddr];
        data_q <= data_mem[raddr];
        if (nwe)
        begin
            next_mem[nwa] <= nwd;
        end
        if (dwe)
        begin
            data_mem[dwa] <= dwd;
        end
    end

    always_comb
    begin
        logic          fin;
        logic [1:0]    fin_st;
        logic [31:0]   fin_vout;
        logic          fin_found;
        logic [5:0]    fin_fpos;
        logic [CW-1:0] fin_rm;

        fin       = 1'b0;
        fin_st    = cll_pkg::STAT_OK;
        fin_vout  = '0;
        fin_found = 1'b0;
        fin_fpos  = '0;
        fin_rm    = '0;

        state_next   = state_reg;
        ret_next     = ret_reg;
        clr_next     = clr_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        spare_next   = spare_reg;
        count_next   = count_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        node_next    = node_reg;
        k_next       = k_reg;
        total_next   = total_reg;
        raw_next     = raw_reg;
        hasprev_next = hasprev_reg;
        back_next    = back_reg;
        val_next     = val_reg;
        vout_next    = vout_reg;
        rm_next      = rm_reg;

        done_next      = 1'b0;
        st_res_next    = st_res_reg;
        vout_res_next  = vout_res_reg;
        found_res_next = found_res_reg;
        fpos_res_next  = fpos_res_reg;
        rm_res_next    = rm_res_reg;
        len_res_next   = len_res_reg;

        raddr = cur_reg;
        nwe   = 1'b0;
        nwa   = '0;
        nwd   = '0;
        dwe   = 1'b0;
        dwa   = node_reg;
        dwd   = val_reg;

        unique case (state_reg)
            S_CLR:
            begin
                nwe = 1'b1;
                nwa = clr_reg;
                nwd = CW'(clr_reg) + CW'(1);
                if (clr_reg == IW'(NODE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + IW'(1);
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    val_next = value;
                    unique case (cmd)
                        cll_pkg::CMD_PUSH_FRONT, cll_pkg::CMD_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                fin    = 1'b1;
                                fin_st = cll_pkg::STAT_FULL;
                            end
                            else
                            begin
                                raddr      = nix(spare_reg);
                                node_next  = nix(spare_reg);
                                back_next  = (cmd == cll_pkg::CMD_PUSH_BACK);
                                state_next = S_ADD;
                            end
                        end
                        cll_pkg::CMD_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                fin    = 1'b1;
                                fin_st = cll_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                raddr      = head_reg;
                                state_next = S_POPF;
                            end
                        end
                        cll_pkg::CMD_POP_BACK:
                        begin
                            if (empty)
                            begin
                                fin    = 1'b1;
                                fin_st = cll_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                raddr      = tail_reg;
                                state_next = S_PB0;
                            end
                        end
                        cll_pkg::CMD_FIND:
                        begin
                            raddr    = head_reg;
                            cur_next = head_reg;
                            k_next   = '0;
                            if (empty)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                state_next = S_FIND;
                            end
                        end
                        cll_pkg::CMD_ERASE:
                        begin
                            priority if (empty)
                            begin
                                fin    = 1'b1;
                                fin_st = cll_pkg::STAT_EMPTY;
                            end
                            else if (pos_w >= cnt_w)
                            begin
                                fin    = 1'b1;
                                fin_st = cll_pkg::STAT_RANGE;
                            end
                            else if (pos_w == '0)
                            begin
                                raddr      = head_reg;
                                state_next = S_POPF;
                            end
                            else if (pos_w == cnt_w - PW'(1))
                            begin
                                raddr      = tail_reg;
                                state_next = S_PB0;
                            end
                            else
                            begin
                                raddr      = head_reg;
                                cur_next   = head_reg;
                                k_next     = CW'(pos_w - PW'(1));
                                ret_next   = S_ER0;
                                state_next = S_WALK;
                            end
                        end
                        cll_pkg::CMD_INSERT:
                        begin
                            priority if (full)
                            begin
                                fin    = 1'b1;
                                fin_st = cll_pkg::STAT_FULL;
                            end
                            else if (pos_w > cnt_w)
                            begin
                                fin    = 1'b1;
                                fin_st = cll_pkg::STAT_RANGE;
                            end
                            else if (pos_w == '0 || pos_w == cnt_w)
                            begin
                                raddr      = nix(spare_reg);
                                node_next  = nix(spare_reg);
                                back_next  = (pos_w != '0);
                                state_next = S_ADD;
                            end
                            else
                            begin
                                raddr      = head_reg;
                                cur_next   = head_reg;
                                k_next     = CW'(pos_w - PW'(1));
                                ret_next   = S_IN0;
                                state_next = S_WALK;
                            end
                        end
                        cll_pkg::CMD_REMOVE_ALL:
                        begin
                            raddr        = head_reg;
                            cur_next     = head_reg;
                            prev_next    = '0;
                            hasprev_next = 1'b0;
                            k_next       = '0;
                            total_next   = count_reg;
                            rm_next      = '0;
                            state_next   = S_RM;
                        end
                        cll_pkg::CMD_CLEAR:
                        begin
                            if (!empty)
                            begin
                                nwe        = 1'b1;
                                nwa        = tail_reg;
                                nwd        = spare_reg;
                                spare_next = CW'(head_reg);
                                count_next = '0;
                            end
                            fin = 1'b1;
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            S_ADD:
            begin
                spare_next = next_q;
                dwe        = 1'b1;
                if (back_reg)
                begin
                    if (empty)
                    begin
                        head_next = node_reg;
                    end
                    else
                    begin
                        nwe = 1'b1;
                        nwa = tail_reg;
                        nwd = CW'(node_reg);
                    end
                    tail_next = node_reg;
                end
                else
                begin
                    if (empty)
                    begin
                        tail_next = node_reg;
                    end
                    else
                    begin
                        nwe = 1'b1;
                        nwa = node_reg;
                        nwd = CW'(head_reg);
                    end
                    head_next = node_reg;
                end
                count_next = count_reg + CW'(1);
                fin        = 1'b1;
            end

            S_POPF:
            begin
                head_next  = nix(next_q);
                nwe        = 1'b1;
                nwa        = head_reg;
                nwd        = spare_reg;
                spare_next = CW'(head_reg);
                count_next = count_reg - CW'(1);
                fin        = 1'b1;
                fin_vout   = data_q;
            end

            S_PB0:
            begin
                vout_next = data_q;
                if (count_reg >= CW'(2))
                begin
                    raddr      = head_reg;
                    cur_next   = head_reg;
                    k_next     = count_reg - CW'(2);
                    ret_next   = S_PBF;
                    state_next = S_WALK;
                end
                else
                begin
                    cur_next   = tail_reg;
                    state_next = S_PBF;
                end
            end

            S_PBF:
            begin
                nwe        = 1'b1;
                nwa        = tail_reg;
                nwd        = spare_reg;
                spare_next = CW'(tail_reg);
                tail_next  = cur_reg;
                count_next = count_reg - CW'(1);
                fin        = 1'b1;
                fin_vout   = vout_reg;
            end

            S_WALK:
            begin
                if (k_reg == '0)
                begin
                    raddr      = cur_reg;
                    state_next = ret_reg;
                end
                else
                begin
                    raddr    = nix(next_q);
                    cur_next = nix(next_q);
                    k_next   = k_reg - CW'(1);
                end
            end

            S_ER0:
            begin
                prev_next  = cur_reg;
                raddr      = nix(next_q);
                node_next  = nix(next_q);
                state_next = S_ER1;
            end

            S_ER1:
            begin
                vout_next  = data_q;
                nwe        = 1'b1;
                nwa        = prev_reg;
                nwd        = next_q;
                state_next = S_ER2;
            end

            S_ER2:
            begin
                nwe        = 1'b1;
                nwa        = node_reg;
                nwd        = spare_reg;
                spare_next = CW'(node_reg);
                count_next = count_reg - CW'(1);
                fin        = 1'b1;
                fin_vout   = vout_reg;
            end

            S_IN0:
            begin
                prev_next  = cur_reg;
                raw_next   = next_q;
                raddr      = nix(spare_reg);
                node_next  = nix(spare_reg);
                state_next = S_IN1;
            end

            S_IN1:
            begin
                spare_next = next_q;
                dwe        = 1'b1;
                nwe        = 1'b1;
                nwa        = node_reg;
                nwd        = raw_reg;
                state_next = S_IN2;
            end

            S_IN2:
            begin
                nwe        = 1'b1;
                nwa        = prev_reg;
                nwd        = CW'(node_reg);
                count_next = count_reg + CW'(1);
                fin        = 1'b1;
            end

            S_FIND:
            begin
                if (k_reg == count_reg)
                begin
                    fin = 1'b1;
                end
                else if (data_q == val_reg)
                begin
                    fin       = 1'b1;
                    fin_found = 1'b1;
                    fin_fpos  = 6'(k_reg);
                end
                else
                begin
                    raddr    = nix(next_q);
                    cur_next = nix(next_q);
                    k_next   = k_reg + CW'(1);
                end
            end

            S_RM:
            begin
                if (k_reg == total_reg)
                begin
                    fin    = 1'b1;
                    fin_rm = rm_reg;
                end
                else if (data_q == val_reg)
                begin
                    // unlink this node onto the free chain
                    raw_next   = next_q;
                    nwe        = 1'b1;
                    nwa        = cur_reg;
                    nwd        = spare_reg;
                    spare_next = CW'(cur_reg);
                    rm_next    = rm_reg + CW'(1);
                    count_next = count_reg - CW'(1);
                    if (!hasprev_reg)
                    begin
                        head_next = nix(next_q);
                        raddr     = nix(next_q);
                        cur_next  = nix(next_q);
                        k_next    = k_reg + CW'(1);
                    end
                    else
                    begin
                        if (cur_reg == tail_reg)
                        begin
                            tail_next = prev_reg;
                        end
                        state_next = S_RM2;
                    end
                end
                else
                begin
                    prev_next    = cur_reg;
                    hasprev_next = 1'b1;
                    raddr        = nix(next_q);
                    cur_next     = nix(next_q);
                    k_next       = k_reg + CW'(1);
                end
            end

            S_RM2:
            begin
                // bridge the previous survivor over the dropped node
                nwe        = 1'b1;
                nwa        = prev_reg;
                nwd        = raw_reg;
                raddr      = nix(raw_reg);
                cur_next   = nix(raw_reg);
                k_next     = k_reg + CW'(1);
                state_next = S_RM;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next     = S_IDLE;
            done_next      = 1'b1;
            st_res_next    = fin_st;
            vout_res_next  = fin_vout;
            found_res_next = fin_found;
            fpos_res_next  = fin_fpos;
            rm_res_next    = 7'(fin_rm);
            len_res_next   = 7'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            ret_reg     <= S_IDLE;
            clr_reg     <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            spare_reg   <= '0;
            count_reg   <= '0;
            k_reg       <= '0;
            total_reg   <= '0;
            hasprev_reg <= 1'b0;
            back_reg    <= 1'b0;
            rm_reg      <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            clr_reg     <= clr_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            spare_reg   <= spare_next;
            count_reg   <= count_next;
            k_reg       <= k_next;
            total_reg   <= total_next;
            hasprev_reg <= hasprev_next;
            back_reg    <= back_next;
            rm_reg      <= rm_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        node_reg      <= node_next;
        raw_reg       <= raw_next;
        val_reg       <= val_next;
        vout_reg      <= vout_next;
        st_res_reg    <= st_res_next;
        vout_res_reg  <= vout_res_next;
        found_res_reg <= found_res_next;
        fpos_res_reg  <= fpos_res_next;
        rm_res_reg    <= rm_res_next;
        len_res_reg   <= len_res_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = st_res_reg;
    assign value_out      = vout_res_reg;
    assign found          = found_res_reg;
    assign found_position = fpos_res_reg;
    assign removed_count  = rm_res_reg;
    assign list_length    = len_res_reg;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int NODES      = 64;
    localparam int CYCLE_CAP  = 800000;
    localparam int RAND_ITEMS = 1400;

    typedef struct packed {
        cll_pkg::status_t status;
        logic [31:0]      value_out;
        logic             found;
        logic [5:0]       found_position;
        logic [6:0]       removed_count;
        logic [6:0]       list_length;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  cmd;
    logic [31:0] value;
    logic [6:0]  position;
    logic        done;
    logic [1:0]  status;
    logic [31:0] value_out;
    logic        found;
    logic [5:0]  found_position;
    logic [6:0]  removed_count;
    logic [6:0]  list_length;

    logic [31:0] list_model[$];
    outcome_t    pending_outcomes[$];
    int          mismatches;
    int          cycles;
    logic [31:0] value_pool[8];

    cursor_linked_list_engine_top #(.NODE_COUNT(NODES)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .value(value), .position(position),
        .done(done), .status(status), .value_out(value_out), .found(found),
        .found_position(found_position), .removed_count(removed_count),
        .list_length(list_length)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Apply one command to the shadow list and return what the engine must report.
    function automatic outcome_t apply_command(logic [3:0] op, logic [31:0] v, logic [6:0] pos);
        outcome_t r;
        int       len;
        int       k;
        r = '0;
        len = list_model.size();
        case (op)
            cll_pkg::CMD_PUSH_FRONT, cll_pkg::CMD_PUSH_BACK:
            begin
                if (len >= NODES)
                    r.status = cll_pkg::STAT_FULL;
                else if (op == cll_pkg::CMD_PUSH_FRONT)
                    list_model.insert(0, v);
                else
                    list_model.insert(len, v);
            end
            cll_pkg::CMD_POP_FRONT:
            begin
                if (len == 0)
                    r.status = cll_pkg::STAT_EMPTY;
                else
                begin
                    r.value_out = list_model[0];
                    list_model.delete(0);
                end
            end
            cll_pkg::CMD_POP_BACK:
            begin
                if (len == 0)
                    r.status = cll_pkg::STAT_EMPTY;
                else
                begin
                    r.value_out = list_model[len - 1];
                    list_model.delete(len - 1);
                end
            end
            cll_pkg::CMD_FIND:
            begin
                for (k = 0; k < len; k++)
                begin
                    if (list_model[k] == v)
                    begin
                        r.found = 1'b1;
                        r.found_position = 6'(k);
                        break;
                    end
                end
            end
            cll_pkg::CMD_ERASE:
            begin
                if (len == 0)
                    r.status = cll_pkg::STAT_EMPTY;
                else if (int'(pos) >= len)
                    r.status = cll_pkg::STAT_RANGE;
                else
                begin
                    r.value_out = list_model[pos];
                    list_model.delete(pos);
                end
            end
            cll_pkg::CMD_INSERT:
            begin
                if (len >= NODES)
                    r.status = cll_pkg::STAT_FULL;
                else if (int'(pos) > len)
                    r.status = cll_pkg::STAT_RANGE;
                else
                    list_model.insert(pos, v);
            end
            cll_pkg::CMD_REMOVE_ALL:
            begin
                for (k = len - 1; k >= 0; k--)
                begin
                    if (list_model[k] == v)
                    begin
                        list_model.delete(k);
                        r.removed_count++;
                    end
                end
            end
            cll_pkg::CMD_CLEAR:
                list_model.delete();
            default:
                ;
        endcase
        r.list_length = 7'(list_model.size());
        return r;
    endfunction

    // Hold the beat until the engine takes it; start stays high for a following beat.
    task automatic send_command(logic [3:0] op, logic [31:0] v, logic [6:0] pos);
        @(negedge clk);
        start    <= 1'b1;
        cmd      <= op;
        value    <= v;
        position <= pos;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        pending_outcomes.insert(pending_outcomes.size(), apply_command(op, v, pos));
    endtask

    task automatic idle_gap(int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic drain_results();
        idle_gap(1);
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (rst_n && done)
        begin
            got = {status, value_out, found, found_position, removed_count, list_length};
            if (pending_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %p", got);
            end
            else
            begin
                want = pending_outcomes[0];
                pending_outcomes.delete(0);
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    task automatic test_empty_list();
        send_command(cll_pkg::CMD_POP_FRONT, 32'h0, 7'd0);
        send_command(cll_pkg::CMD_POP_BACK, 32'h0, 7'd0);
        send_command(cll_pkg::CMD_ERASE, 32'h0, 7'd0);
        send_command(cll_pkg::CMD_REMOVE_ALL, 32'h5, 7'd0);
        send_command(cll_pkg::CMD_CLEAR, 32'h0, 7'd0);
        send_command(cll_pkg::CMD_FIND, 32'h0, 7'd0);
        send_command(cll_pkg::CMD_INSERT, 32'h1, 7'd1);
    endtask

    task automatic test_basic_ops();
        send_command(cll_pkg::CMD_INSERT, 32'h7FFF_FFFF, 7'd0);
        send_command(cll_pkg::CMD_PUSH_FRONT, 32'h8000_0000, 7'd0);
        send_command(cll_pkg::CMD_PUSH_BACK, 32'hFFFF_FFFF, 7'd127);
        send_command(cll_pkg::CMD_INSERT, 32'h0000_0000, 7'd3);
        send_command(cll_pkg::CMD_INSERT, 32'hFFFF_FFFF, 7'd2);
        send_command(cll_pkg::CMD_FIND, 32'hFFFF_FFFF, 7'd0);
        send_command(cll_pkg::CMD_FIND, 32'h1234_5678, 7'd0);
        send_command(cll_pkg::CMD_ERASE, 32'h0, 7'd0);
        send_command(cll_pkg::CMD_ERASE, 32'h0, 7'd1);
        send_command(cll_pkg::CMD_ERASE, 32'h0, 7'd64);
        send_command(cll_pkg::CMD_INSERT, 32'h0, 7'd127);
        send_command(cll_pkg::CMD_REMOVE_ALL, 32'hFFFF_FFFF, 7'd0);
        send_command(cll_pkg::CMD_POP_BACK, 32'h0, 7'd0);
        send_command(4'hF, 32'hFFFF_FFFF, 7'd127);
        send_command(4'h9, 32'h0, 7'd0);
        send_command(cll_pkg::CMD_CLEAR, 32'h0, 7'd0);
    endtask

    task automatic test_full_list();
        int i;
        for (i = 0; i < NODES; i++)
            send_command(cll_pkg::CMD_PUSH_BACK, value_pool[i % 8], 7'd0);
        send_command(cll_pkg::CMD_PUSH_FRONT, 32'h1, 7'd0);
        send_command(cll_pkg::CMD_INSERT, 32'h1, 7'd100);
        send_command(cll_pkg::CMD_ERASE, 32'h0, 7'd63);
        send_command(cll_pkg::CMD_INSERT, 32'h2, 7'd63);
        send_command(cll_pkg::CMD_FIND, value_pool[7], 7'd0);
        send_command(cll_pkg::CMD_POP_BACK, 32'h0, 7'd0);
        send_command(cll_pkg::CMD_REMOVE_ALL, value_pool[3], 7'd0);
        send_command(cll_pkg::CMD_CLEAR, 32'h0, 7'd0);
    endtask

    task automatic test_random_traffic();
        int          sent;
        int          burst;
        int          pick;
        bit          grow;
        logic [3:0]  op;
        logic [31:0] v;
        logic [6:0]  pos;
        sent = 0;
        grow = 1'b1;
        while (sent < RAND_ITEMS)
        begin
            burst = $urandom_range(1, 20);
            repeat (burst)
            begin
                if (list_model.size() >= NODES)
                    grow = 1'b0;
                else if (list_model.size() == 0)
                    grow = 1'b1;
                else if ($urandom_range(0, 60) == 0)
                    grow = ~grow;
                pick = $urandom_range(0, 99);
                if (pick < 2)
                    op = 4'($urandom_range(9, 15));
                else if (pick < 4)
                    op = cll_pkg::CMD_CLEAR;
                else if (grow && pick < 50)
                    op = ($urandom_range(0, 2) == 0) ? cll_pkg::CMD_INSERT
                         : 4'($urandom_range(0, 1));
                else
                    op = 4'($urandom_range(0, 7));
                v = ($urandom_range(0, 3) != 0) ? value_pool[$urandom_range(0, 7)] : $urandom;
                if ($urandom_range(0, 9) == 0)
                    pos = 7'($urandom);
                else
                    pos = 7'($urandom_range(0, list_model.size()));
                send_command(op, v, pos);
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_gap($urandom_range(1, 12));
            if (sent % 500 < burst)
                drain_results();
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = '0;
        value      = '0;
        position   = '0;
        mismatches = 0;
        cycles     = 0;
        value_pool = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h1, 32'h55AA_55AA, 32'hAA55_AA55, 32'h2A};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_list();
        test_basic_ops();
        drain_results();
        test_full_list();
        test_random_traffic();

        idle_gap(1);
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (140) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== cursor_linked_list_engine_top.f =====
hdl/cll_pkg.sv
hdl/cursor_linked_list_engine_top.sv
bench/testbench.sv
